@@ src/vgtl_pkg.sv @@
// Shared constants and types for the vector grid trilinear lookup core.
`timescale 1ns / 1ps
package vgtl_pkg;
    localparam int MAX_SIDE    = 32;
    localparam int SIDE_BITS   = $clog2(MAX_SIDE);
    localparam int ADDR_BITS   = 3 * SIDE_BITS;
    localparam int CELLS       = MAX_SIDE * MAX_SIDE * MAX_SIDE;
    localparam int SAMPLE_BITS = 32;
    localparam int FRAC_BITS   = 16;

    localparam logic [2:0] REG_SIDE_X  = 3'd0;
    localparam logic [2:0] REG_SIDE_Y  = 3'd1;
    localparam logic [2:0] REG_SIDE_Z  = 3'd2;
    localparam logic [2:0] REG_SCALE_X = 3'd3;
    localparam logic [2:0] REG_SCALE_Y = 3'd4;
    localparam logic [2:0] REG_SCALE_Z = 3'd5;
    localparam logic [2:0] REG_SHIFT_X = 3'd6;

    // three components, index 0 is x
    typedef logic [2:0][SAMPLE_BITS-1:0] vec_t;
endpackage

@@ src/vgtl_ram.sv @@
// Generic single-port synchronous RAM with registered read.
`timescale 1ns / 1ps
module vgtl_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     clk,
    input  logic                     en,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] addr,
    input  logic [WIDTH-1:0]         wdata,
    output logic [WIDTH-1:0]         rdata
);
    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            if (we)
                mem[addr] <= wdata;
            else
                rdata_reg <= mem[addr];
        end
    end

    assign rdata = rdata_reg;
endmodule

@@ src/vgtl_blend.sv @@
// Three-lane linear blend a + round((b - a) * f), halves rounded upward.
`timescale 1ns / 1ps
module vgtl_blend (
    input  vgtl_pkg::vec_t                   a,
    input  vgtl_pkg::vec_t                   b,
    input  logic [vgtl_pkg::FRAC_BITS-1:0]   f,
    output vgtl_pkg::vec_t                   y
);
    import vgtl_pkg::*;

    localparam int PW = SAMPLE_BITS + FRAC_BITS + 2;

    logic signed [SAMPLE_BITS:0] d [3];
    logic signed [PW-1:0]        p [3];
    logic signed [PW-1:0]        r [3];

    always_comb
    begin
        for (int k = 0; k < 3; k++)
        begin
            d[k] = $signed({b[k][SAMPLE_BITS-1], b[k]})
                 - $signed({a[k][SAMPLE_BITS-1], a[k]});
            p[k] = PW'(d[k]) * PW'($signed({1'b0, f}));
            r[k] = (p[k] + PW'(1 << (FRAC_BITS - 1))) >>> FRAC_BITS;
            y[k] = a[k] + r[k][SAMPLE_BITS-1:0];
        end
    end
endmodule

@@ src/vector_grid_trilinear_lookup_core.sv @@
// Vector grid trilinear lookup: top level with sequencer and grid store.
//
// Usage: a transaction is taken when start is high and busy is low.
// req_type 0 writes cell (cell_x, cell_y, cell_z) with value_x/y/z in that
// same cycle; it gives no result and busy stays low.
// req_type 1 queries position pos_x/y/z. busy rises and the answer appears
// on field_x/y/z and outside for one cycle with done high, after these steps:
//   outside position      x, y, z scaling and range check
//   upper-edge position   those, then one grid read
//   interior position     those, then eight grid reads, seven blends
// The next transaction is taken in the cycle that done is high. Query length
// is set by the single-port grid store, read one corner a cycle, and the
// one shared 32x33 multiplier used for the three axis scalings. The receiver
// cannot stall; done is a one-cycle strobe. Configuration is written
// through cfg_we/cfg_index/cfg_data while idle, which the user must ensure;
// the block does not enforce it. Reset restores the register defaults and
// returns the sequencer to idle; grid contents are undefined until written.
`timescale 1ns / 1ps
module vector_grid_trilinear_lookup_core (
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               start,
    output logic                               busy,
    input  logic                               req_type,
    input  logic signed [31:0]                 pos_x,
    input  logic signed [31:0]                 pos_y,
    input  logic signed [31:0]                 pos_z,
    input  logic [4:0]                         cell_x,
    input  logic [4:0]                         cell_y,
    input  logic [4:0]                         cell_z,
    input  logic signed [31:0]                 value_x,
    input  logic signed [31:0]                 value_y,
    input  logic signed [31:0]                 value_z,
    input  logic                               cfg_we,
    input  logic [2:0]                         cfg_index,
    input  logic [31:0]                        cfg_data,
    output logic                               done,
    output logic signed [31:0]                 field_x,
    output logic signed [31:0]                 field_y,
    output logic signed [31:0]                 field_z,
    output logic                               outside
);
    import vgtl_pkg::*;

    localparam logic [3:0] S_IDLE  = 4'd0;
    localparam logic [3:0] S_MX    = 4'd1;
    localparam logic [3:0] S_MY    = 4'd2;
    localparam logic [3:0] S_MZ    = 4'd3;
    localparam logic [3:0] S_CHK   = 4'd4;
    localparam logic [3:0] S_EDGE  = 4'd5;
    localparam logic [3:0] S_EDGEW = 4'd6;
    localparam logic [3:0] S_RD    = 4'd7;
    localparam logic [3:0] S_RDW   = 4'd8;
    localparam logic [3:0] S_YA    = 4'd9;
    localparam logic [3:0] S_YB    = 4'd10;
    localparam logic [3:0] S_XB    = 4'd11;

    // cell count above MAX_SIDE acts as MAX_SIDE; zero gives -1 (all outside)
    function automatic logic signed [6:0] eff_lim(input logic [5:0] side);
        if (side > 6'(MAX_SIDE))
            return 7'(MAX_SIDE - 1);
        return $signed({1'b0, side}) - 7'sd1;
    endfunction

    logic [5:0]  side_x_reg, side_y_reg, side_z_reg;
    logic [31:0] scale_x_reg, scale_y_reg, scale_z_reg;
    logic signed [31:0] shift_x_reg;

    logic [3:0] state_reg, state_next;
    logic [2:0] cnt_reg;
    logic       rd_vld_reg;
    logic [2:0] rd_idx_reg;

    logic signed [31:0] px_reg, py_reg, pz_reg;
    logic signed [65:0] tx_reg, ty_reg, tz_reg;
    logic [SIDE_BITS-1:0] xc_reg, yc_reg, zc_reg;
    logic [FRAC_BITS-1:0] xf_reg, yf_reg, zf_reg;

    vec_t a_reg, w1_reg, w2_reg;
    vec_t zr_reg [4];

    logic done_reg, outside_reg;
    vec_t res_reg;

    logic signed [6:0] lim_x, lim_y, lim_z;
    assign lim_x = eff_lim(side_x_reg);
    assign lim_y = eff_lim(side_y_reg);
    assign lim_z = eff_lim(side_z_reg);

    logic accept;
    assign accept = start && !busy;

    // shared axis scaling
    logic signed [31:0] mul_a;
    logic [31:0]        mul_b;
    logic signed [6:0]  lim_sel;
    logic signed [31:0] shift_sel;
    logic signed [64:0] prod;
    logic signed [65:0] t_next;

    always_comb
    begin
        case (state_reg)
            S_MX:
            begin
                mul_a = px_reg; mul_b = scale_x_reg; lim_sel = lim_x; shift_sel = shift_x_reg;
            end
            S_MY:
            begin
                mul_a = py_reg; mul_b = scale_y_reg; lim_sel = lim_y; shift_sel = '0;
            end
            default:
            begin
                mul_a = pz_reg; mul_b = scale_z_reg; lim_sel = lim_z; shift_sel = '0;
            end
        endcase
    end

    assign prod   = 65'(mul_a) * $signed({1'b0, mul_b});
    assign t_next = 66'(prod) + (66'(lim_sel) <<< (FRAC_BITS - 1)) - 66'(shift_sel);

    logic out_any, edge_any;
    assign out_any = tx_reg[65] || (tx_reg > (66'(lim_x) <<< FRAC_BITS))
                  || ty_reg[65] || (ty_reg > (66'(lim_y) <<< FRAC_BITS))
                  || tz_reg[65] || (tz_reg > (66'(lim_z) <<< FRAC_BITS));
    assign edge_any = (tx_reg[FRAC_BITS +: SIDE_BITS] == lim_x[SIDE_BITS-1:0])
                   || (ty_reg[FRAC_BITS +: SIDE_BITS] == lim_y[SIDE_BITS-1:0])
                   || (tz_reg[FRAC_BITS +: SIDE_BITS] == lim_z[SIDE_BITS-1:0]);

    // grid store
    logic                 ram_en, ram_we;
    logic [ADDR_BITS-1:0] ram_addr;
    vec_t                 ram_wdata, ram_rdata;

    always_comb
    begin
        ram_en    = 1'b0;
        ram_we    = 1'b0;
        ram_addr  = {cell_x, cell_y, cell_z};
        ram_wdata = {value_z, value_y, value_x};
        case (state_reg)
            S_IDLE:
            begin
                ram_en = accept && !req_type;
                ram_we = accept && !req_type;
            end
            S_EDGE:
            begin
                ram_en   = 1'b1;
                ram_addr = {xc_reg, yc_reg, zc_reg};
            end
            S_RD:
            begin
                ram_en   = 1'b1;
                ram_addr = {xc_reg + SIDE_BITS'(cnt_reg[2]),
                            yc_reg + SIDE_BITS'(cnt_reg[1]),
                            zc_reg + SIDE_BITS'(cnt_reg[0])};
            end
            default:
            begin
                ram_en = 1'b0;
            end
        endcase
    end

    vgtl_ram #(
        .WIDTH ($bits(vec_t)),
        .DEPTH (CELLS)
    ) u_store (
        .clk   (clk),
        .en    (ram_en),
        .we    (ram_we),
        .addr  (ram_addr),
        .wdata (ram_wdata),
        .rdata (ram_rdata)
    );

    // shared blend: z pairs as they arrive, then y, then x
    vec_t               bl_a, bl_b, bl_y;
    logic [FRAC_BITS-1:0] bl_f;

    always_comb
    begin
        case (state_reg)
            S_YA:
            begin
                bl_a = zr_reg[0]; bl_b = zr_reg[1]; bl_f = yf_reg;
            end
            S_YB:
            begin
                bl_a = zr_reg[2]; bl_b = zr_reg[3]; bl_f = yf_reg;
            end
            S_XB:
            begin
                bl_a = w1_reg; bl_b = w2_reg; bl_f = xf_reg;
            end
            default:
            begin
                bl_a = a_reg; bl_b = ram_rdata; bl_f = zf_reg;
            end
        endcase
    end

    vgtl_blend u_blend (
        .a (bl_a),
        .b (bl_b),
        .f (bl_f),
        .y (bl_y)
    );

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            S_IDLE:  state_next = (accept && req_type) ? S_MX : S_IDLE;
            S_MX:    state_next = S_MY;
            S_MY:    state_next = S_MZ;
            S_MZ:    state_next = S_CHK;
            S_CHK:   state_next = out_any ? S_IDLE : (edge_any ? S_EDGE : S_RD);
            S_EDGE:  state_next = S_EDGEW;
            S_EDGEW: state_next = S_IDLE;
            S_RD:    state_next = (cnt_reg == 3'd7) ? S_RDW : S_RD;
            S_RDW:   state_next = S_YA;
            S_YA:    state_next = S_YB;
            S_YB:    state_next = S_XB;
            S_XB:    state_next = S_IDLE;
            default: state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= S_IDLE;
            cnt_reg     <= '0;
            rd_vld_reg  <= 1'b0;
            done_reg    <= 1'b0;
            side_x_reg  <= 6'd32;
            side_y_reg  <= 6'd32;
            side_z_reg  <= 6'd32;
            scale_x_reg <= 32'd65536;
            scale_y_reg <= 32'd65536;
            scale_z_reg <= 32'd65536;
            shift_x_reg <= '0;
        end
        else
        begin
            state_reg  <= state_next;
            rd_vld_reg <= (state_reg == S_RD);
            done_reg   <= (state_reg == S_CHK && out_any) || (state_reg == S_EDGEW)
                       || (state_reg == S_XB);
            if (state_reg == S_RD)
                cnt_reg <= cnt_reg + 3'd1;
            else
                cnt_reg <= '0;
            if (cfg_we)
            begin
                case (cfg_index)
                    REG_SIDE_X:  side_x_reg  <= cfg_data[5:0];
                    REG_SIDE_Y:  side_y_reg  <= cfg_data[5:0];
                    REG_SIDE_Z:  side_z_reg  <= cfg_data[5:0];
                    REG_SCALE_X: scale_x_reg <= cfg_data;
                    REG_SCALE_Y: scale_y_reg <= cfg_data;
                    REG_SCALE_Z: scale_z_reg <= cfg_data;
                    REG_SHIFT_X: shift_x_reg <= $signed(cfg_data);
                    default:     ;
                endcase
            end
        end
    end

    always_ff @(posedge clk)
    begin
        rd_idx_reg <= cnt_reg;
        if (accept && req_type)
        begin
            px_reg <= pos_x;
            py_reg <= pos_y;
            pz_reg <= pos_z;
        end
        if (state_reg == S_MX) tx_reg <= t_next;
        if (state_reg == S_MY) ty_reg <= t_next;
        if (state_reg == S_MZ) tz_reg <= t_next;
        if (state_reg == S_CHK)
        begin
            xc_reg <= tx_reg[FRAC_BITS +: SIDE_BITS];
            yc_reg <= ty_reg[FRAC_BITS +: SIDE_BITS];
            zc_reg <= tz_reg[FRAC_BITS +: SIDE_BITS];
            xf_reg <= tx_reg[FRAC_BITS-1:0];
            yf_reg <= ty_reg[FRAC_BITS-1:0];
            zf_reg <= tz_reg[FRAC_BITS-1:0];
            res_reg     <= '0;
            outside_reg <= 1'b1;
        end
        if (rd_vld_reg)
        begin
            if (!rd_idx_reg[0])
                a_reg <= ram_rdata;
            else
                zr_reg[rd_idx_reg[2:1]] <= bl_y;
        end
        if (state_reg == S_YA) w1_reg <= bl_y;
        if (state_reg == S_YB) w2_reg <= bl_y;
        if (state_reg == S_EDGEW)
        begin
            res_reg     <= ram_rdata;
            outside_reg <= 1'b0;
        end
        if (state_reg == S_XB)
        begin
            res_reg     <= bl_y;
            outside_reg <= 1'b0;
        end
    end

    assign busy    = (state_reg != S_IDLE);
    assign done    = done_reg;
    assign field_x = $signed(res_reg[0]);
    assign field_y = $signed(res_reg[1]);
    assign field_z = $signed(res_reg[2]);
    assign outside = outside_reg;

    a_outside_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (done && outside) |-> (res_reg == '0))
        else $error("outside answer not zero");

    a_done_single: assert property (@(posedge clk) disable iff (!rst_n)
        done |=> !done)
        else $error("result strobe longer than one cycle");

    a_write_idle: assert property (@(posedge clk) disable iff (!rst_n)
        ram_we |-> (state_reg == S_IDLE))
        else $error("grid write outside idle");

    a_query_busy: assert property (@(posedge clk) disable iff (!rst_n)
        (accept && req_type) |=> busy)
        else $error("query taken without going busy");

    a_done_idle: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> !busy)
        else $error("result while sequencer still running");
endmodule

@@ bench/vector_grid_trilinear_lookup_core_tb.sv @@
// Self-checking bench for the vector grid trilinear lookup core.
`timescale 1ns / 1ps
module vector_grid_trilinear_lookup_core_tb;
    import vgtl_pkg::*;

    typedef struct {
        logic               req_type;
        logic signed [31:0] pos_x, pos_y, pos_z;
        logic [4:0]         cell_x, cell_y, cell_z;
        logic signed [31:0] value_x, value_y, value_z;
    } grid_cmd_t;

    typedef struct {
        logic signed [31:0] fx, fy, fz;
        logic               outside;
    } field_ans_t;

    localparam logic REQ_WRITE = 1'b0;
    localparam logic REQ_QUERY = 1'b1;
    localparam longint ONE_Q   = 64'sd1 << FRAC_BITS;
    localparam longint HALF_Q  = 64'sd1 << (FRAC_BITS - 1);

    logic clk = 1'b0;
    logic rst_n = 1'b0;
    logic start = 1'b0;
    logic busy;
    logic req_type = 1'b0;
    logic signed [31:0] pos_x = '0, pos_y = '0, pos_z = '0;
    logic [4:0] cell_x = '0, cell_y = '0, cell_z = '0;
    logic signed [31:0] value_x = '0, value_y = '0, value_z = '0;
    logic cfg_we = 1'b0;
    logic [2:0] cfg_index = REG_SIDE_X;
    logic [31:0] cfg_data = '0;
    logic done;
    logic signed [31:0] field_x, field_y, field_z;
    logic outside;

    vector_grid_trilinear_lookup_core DUT (.*);

    always
    begin
        #10 clk = 1'b1;
        #10 clk = 1'b0;
    end

    // configuration copy shared by stimulus and prediction; changed only when idle
    logic [5:0]  side_x = 6'd32, side_y = 6'd32, side_z = 6'd32;
    logic [31:0] scale_x = 32'd65536, scale_y = 32'd65536, scale_z = 32'd65536;
    logic signed [31:0] shift_x = '0;

    longint grid_x [CELLS];
    longint grid_y [CELLS];
    longint grid_z [CELLS];
    bit     planned [CELLS];

    grid_cmd_t  pending_cmds [$];
    field_ans_t expected_fields [$];
    int mismatches = 0;
    bit calm = 1'b0;

    function automatic int cell_addr(longint x, longint y, longint z);
        return int'((x * MAX_SIDE + y) * MAX_SIDE + z);
    endfunction

    function automatic longint axis_limit(logic [5:0] side);
        return (side > MAX_SIDE) ? MAX_SIDE - 1 : longint'(side) - 1;
    endfunction

    function automatic bit place(input logic signed [31:0] p, input logic [31:0] sc,
                                 input longint sh, input longint lim,
                                 output longint corner, output longint frac);
        longint pp, ss, t;
        pp = p;
        ss = sc;
        t = pp * ss + lim * HALF_Q - sh;
        corner = t >>> FRAC_BITS;
        frac = t & (ONE_Q - 1);
        return !(t < 0 || t > lim * ONE_Q);
    endfunction

    function automatic longint mix(longint a, longint b, longint f);
        longint d, hi, lo;
        d = b - a;
        hi = d >>> FRAC_BITS;
        lo = d - hi * ONE_Q;
        return a + hi * f + ((lo * f + HALF_Q) >>> FRAC_BITS);
    endfunction

    function automatic logic signed [31:0] clip32(longint v);
        if (v > 64'sd2147483647)
            return 32'sh7fffffff;
        if (v < -64'sd2147483648)
            return 32'sh80000000;
        return v[31:0];
    endfunction

    function automatic longint trilerp(int k, longint xl, longint yl, longint zl,
                                       longint xf, longint yf, longint zf);
        longint c [8];
        longint w1, w2;
        for (int i = 0; i < 8; i++)
        begin
            int a;
            a = cell_addr(xl + i[2], yl + i[1], zl + i[0]);
            c[i] = (k == 0) ? grid_x[a] : (k == 1) ? grid_y[a] : grid_z[a];
        end
        w1 = mix(mix(c[0], c[1], zf), mix(c[2], c[3], zf), yf);
        w2 = mix(mix(c[4], c[5], zf), mix(c[6], c[7], zf), yf);
        return mix(w1, w2, xf);
    endfunction

    // applies one accepted transaction to the grid copy, queues the answer of a query
    task automatic apply_cmd(grid_cmd_t c);
        longint lx, ly, lz, xl, yl, zl, xf, yf, zf;
        field_ans_t r;
        int a;
        if (c.req_type == REQ_WRITE)
        begin
            a = cell_addr(c.cell_x, c.cell_y, c.cell_z);
            grid_x[a] = c.value_x;
            grid_y[a] = c.value_y;
            grid_z[a] = c.value_z;
            return;
        end
        lx = axis_limit(side_x);
        ly = axis_limit(side_y);
        lz = axis_limit(side_z);
        r = '{fx: '0, fy: '0, fz: '0, outside: 1'b1};
        if (place(c.pos_x, scale_x, shift_x, lx, xl, xf) &&
            place(c.pos_y, scale_y, 0, ly, yl, yf) &&
            place(c.pos_z, scale_z, 0, lz, zl, zf))
        begin
            r.outside = 1'b0;
            if (xl < lx && yl < ly && zl < lz)
            begin
                r.fx = clip32(trilerp(0, xl, yl, zl, xf, yf, zf));
                r.fy = clip32(trilerp(1, xl, yl, zl, xf, yf, zf));
                r.fz = clip32(trilerp(2, xl, yl, zl, xf, yf, zf));
            end
            else
            begin
                a = cell_addr(xl, yl, zl);
                r.fx = clip32(grid_x[a]);
                r.fy = clip32(grid_y[a]);
                r.fz = clip32(grid_z[a]);
            end
        end
        expected_fields.push_back(r);
    endtask

    function automatic logic signed [31:0] sample_value();
        case ($urandom_range(0, 7))
            0: return 32'sh7fffffff;
            1: return 32'sh80000000;
            2: return $urandom_range(0, 3) - 2;
            default: return $urandom;
        endcase
    endfunction

    task automatic queue_write(logic [4:0] x, logic [4:0] y, logic [4:0] z);
        grid_cmd_t c;
        c.req_type = REQ_WRITE;
        c.pos_x = $urandom;
        c.pos_y = $urandom;
        c.pos_z = $urandom;
        c.cell_x = x;
        c.cell_y = y;
        c.cell_z = z;
        c.value_x = sample_value();
        c.value_y = sample_value();
        c.value_z = sample_value();
        planned[cell_addr(x, y, z)] = 1'b1;
        pending_cmds.push_back(c);
    endtask

    task automatic ensure_cell(longint x, longint y, longint z);
        if (!planned[cell_addr(x, y, z)])
            queue_write(x[4:0], y[4:0], z[4:0]);
    endtask

    // a query, preceded by writes of any cell it reads that has never been written
    task automatic queue_query(logic signed [31:0] px, logic signed [31:0] py,
                               logic signed [31:0] pz);
        grid_cmd_t c;
        longint lx, ly, lz, xl, yl, zl, xf, yf, zf;
        lx = axis_limit(side_x);
        ly = axis_limit(side_y);
        lz = axis_limit(side_z);
        if (place(px, scale_x, shift_x, lx, xl, xf) && place(py, scale_y, 0, ly, yl, yf) &&
            place(pz, scale_z, 0, lz, zl, zf))
        begin
            if (xl < lx && yl < ly && zl < lz)
            begin
                for (int i = 0; i < 8; i++)
                    ensure_cell(xl + i[2], yl + i[1], zl + i[0]);
            end
            else
                ensure_cell(xl, yl, zl);
        end
        c.req_type = REQ_QUERY;
        c.pos_x = px;
        c.pos_y = py;
        c.pos_z = pz;
        c.cell_x = 5'($urandom);
        c.cell_y = 5'($urandom);
        c.cell_z = 5'($urandom);
        c.value_x = $urandom;
        c.value_y = $urandom;
        c.value_z = $urandom;
        pending_cmds.push_back(c);
    endtask

    // position that lands near grid coordinate tt (Q.16) on one axis
    function automatic logic signed [31:0] pos_near(longint tt, longint lim,
                                                    logic [31:0] sc, longint sh);
        longint n, ss, q;
        if (sc == 0)
            return $urandom;
        ss = sc;
        n = tt - lim * HALF_Q + sh;
        q = n / ss;
        if (n % ss != 0 && n < 0)
            q--;
        if (q > 64'sd2147483647)
            q = 64'sd2147483647;
        if (q < -64'sd2147483648)
            q = -64'sd2147483648;
        return q[31:0];
    endfunction

    function automatic logic signed [31:0] pick_pos(longint lim, logic [31:0] sc, longint sh);
        int r;
        longint span, tt;
        r = $urandom_range(0, 99);
        span = (lim < 0) ? 0 : lim * ONE_Q;
        if (r < 70)
            tt = (longint'($urandom) * (span + 1)) >>> 32;
        else if (r < 78)
            tt = 0;
        else if (r < 88)
            tt = span;
        else if (r < 92)
            tt = -1 - longint'($urandom_range(0, 70000));
        else if (r < 96)
            tt = span + 1 + longint'($urandom_range(0, 70000));
        else
            return $urandom;
        return pos_near(tt, lim, sc, sh);
    endfunction

    // count includes the writes that fill cells a query needs
    task automatic queue_random(int count);
        int target;
        target = pending_cmds.size() + count;
        while (pending_cmds.size() < target)
        begin
            if ($urandom_range(0, 99) < 20)
                queue_write(5'($urandom), 5'($urandom), 5'($urandom));
            else
                queue_query(pick_pos(axis_limit(side_x), scale_x, shift_x),
                            pick_pos(axis_limit(side_y), scale_y, 0),
                            pick_pos(axis_limit(side_z), scale_z, 0));
        end
    endtask

    task automatic wait_idle(int settle);
        while (pending_cmds.size() != 0 || start || expected_fields.size() != 0)
            @(posedge clk);
        repeat (settle) @(posedge clk);
    endtask

    task automatic set_config(logic [5:0] sx, logic [5:0] sy, logic [5:0] sz,
                              logic [31:0] cx, logic [31:0] cy, logic [31:0] cz,
                              logic signed [31:0] sh);
        logic [31:0] vals [7];
        logic [2:0]  idx [7];
        vals = '{sx, sy, sz, cx, cy, cz, sh};
        idx = '{REG_SIDE_X, REG_SIDE_Y, REG_SIDE_Z, REG_SCALE_X, REG_SCALE_Y,
                REG_SCALE_Z, REG_SHIFT_X};
        wait_idle(24);
        for (int i = 0; i < 7; i++)
        begin
            cfg_we <= 1'b1;
            cfg_index <= idx[i];
            cfg_data <= vals[i];
            @(posedge clk);
        end
        cfg_we <= 1'b0;
        side_x = sx;
        side_y = sy;
        side_z = sz;
        scale_x = cx;
        scale_y = cy;
        scale_z = cz;
        shift_x = sh;
        calm = ($urandom_range(0, 3) == 0);
    endtask

    function automatic logic [5:0] rand_side();
        return ($urandom_range(0, 9) == 0) ? 6'd32 : 6'($urandom_range(2, 6));
    endfunction

    function automatic logic [31:0] rand_scale();
        case ($urandom_range(0, 5))
            0: return $urandom;
            1: return 32'd65536 << $urandom_range(0, 4);
            2: return $urandom_range(1, 65536);
            default: return 32'd65536 >> $urandom_range(0, 3);
        endcase
    endfunction

    // driver: holds start until the transaction is taken, then gaps at random
    int gap = 0;
    grid_cmd_t cur;
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (start && !busy)
                apply_cmd(cur);
            if (!(start && busy))
            begin
                if (gap > 0)
                begin
                    gap--;
                    start <= 1'b0;
                end
                else if (pending_cmds.size() != 0)
                begin
                    cur = pending_cmds.pop_front();
                    start <= 1'b1;
                    req_type <= cur.req_type;
                    pos_x <= cur.pos_x;
                    pos_y <= cur.pos_y;
                    pos_z <= cur.pos_z;
                    cell_x <= cur.cell_x;
                    cell_y <= cur.cell_y;
                    cell_z <= cur.cell_z;
                    value_x <= cur.value_x;
                    value_y <= cur.value_y;
                    value_z <= cur.value_z;
                    if (calm || $urandom_range(0, 9) < 6)
                        gap = 0;
                    else if ($urandom_range(0, 9) < 8)
                        gap = $urandom_range(1, 3);
                    else
                        gap = $urandom_range(10, 40);
                end
                else
                    start <= 1'b0;
            end
        end
    end

    // monitor
    always @(posedge clk)
    begin
        field_ans_t e;
        if (rst_n && done)
        begin
            if (expected_fields.size() == 0)
            begin
                mismatches++;
                if (mismatches <= 10)
                    $display("unexpected result x=%0d y=%0d z=%0d outside=%0b",
                             field_x, field_y, field_z, outside);
            end
            else
            begin
                e = expected_fields.pop_front();
                if (field_x !== e.fx || field_y !== e.fy || field_z !== e.fz ||
                    outside !== e.outside)
                begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("mismatch: expected %0d %0d %0d out=%0b, got %0d %0d %0d out=%0b",
                                 e.fx, e.fy, e.fz, e.outside,
                                 field_x, field_y, field_z, outside);
                end
            end
        end
    end

    initial
    begin
        #50_000_000;
        $display("vector_grid_trilinear_lookup_core_tb failed");
        $finish;
    end

    initial
    begin
        repeat (11) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed: grid corners, position extremes, edges
        queue_write(5'd0, 5'd0, 5'd0);
        queue_write(5'd31, 5'd31, 5'd31);
        queue_query(32'sh80000000, 32'sh80000000, 32'sh80000000);
        queue_query(32'sh7fffffff, 32'sh7fffffff, 32'sh7fffffff);
        queue_query(32'sd0, 32'sd0, 32'sd0);
        queue_query(-32'sd15, -32'sd15, -32'sd15);
        queue_query(32'sd15, 32'sd15, 32'sd15);
        queue_query(32'sd16, 32'sd0, 32'sd0);
        queue_query(-32'sd16, 32'sd0, 32'sd0);
        queue_random(140);

        set_config(6'd3, 6'd3, 6'd3, 32'd65536, 32'd65536, 32'd65536, 32'sd0);
        queue_query(-32'sd1, -32'sd1, -32'sd1);
        queue_query(32'sd1, 32'sd1, 32'sd1);
        queue_query(32'sd1, 32'sd0, -32'sd1);
        queue_query(32'sd2, 32'sd0, 32'sd0);
        queue_random(150);

        set_config(6'd2, 6'd2, 6'd2, 32'hffffffff, 32'd0, 32'd32768, 32'sh80000000);
        queue_random(80);
        set_config(6'd2, 6'd2, 6'd2, 32'd1, 32'd1, 32'd1, 32'sh7fffffff);
        queue_random(80);
        set_config(6'd1, 6'd63, 6'd33, 32'd65536, 32'd65536, 32'd65536, 32'sd0);
        queue_query(32'sd0, 32'sd0, 32'sd0);
        queue_random(100);
        set_config(6'd4, 6'd0, 6'd4, 32'd65536, 32'd65536, 32'd65536, 32'sd0);
        queue_random(40);

        for (int ph = 0; ph < 8; ph++)
        begin
            set_config(rand_side(), rand_side(), rand_side(), rand_scale(), rand_scale(),
                       rand_scale(), ($urandom_range(0, 2) == 0) ? $urandom
                                                                  : $urandom_range(0, 262144) - 131072);
            queue_random(130);
        end

        wait_idle(40);
        if (mismatches == 0)
            $display("vector_grid_trilinear_lookup_core_tb passed");
        else
            $display("vector_grid_trilinear_lookup_core_tb failed");
        $finish;
    end
endmodule
